[src/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the CRC-16/ARC frame builder
// Op codes, queue command format, header reset values and the byte-wise
// CRC-16/ARC update.
// ----------------------------------------------------------------------------
package cfb_pkg;

  // Input op codes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_HDR_ONE   = 2'd0;
  localparam logic [1:0] REG_HDR_TWO   = 2'd1;
  localparam logic [1:0] REG_HDR_THREE = 2'd2;

  // Header register reset values
  localparam logic [7:0] HDR_ONE_RST   = 8'h12;
  localparam logic [7:0] HDR_TWO_RST   = 8'h34;
  localparam logic [7:0] HDR_THREE_RST = 8'h56;

  // Command byte plus three header bytes
  localparam int HDR_BYTES = 4;

  // Reflected CRC-16/ARC polynomial
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PAY,
    CMD_FIN
  } cmd_kind_t;

  // One queued command: kind, data byte, overflow flag of the frame so far
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       ovf;
  } cmd_t;

  // CRC-16/ARC over one byte, LSB first
  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/crc16_arc_frame_builder_top.sv]
// Path: an accepted item that yields a command is written into the command queue, popped
// by the back-end emitter and emitted through the output register; the emitter drives bytes
// into the output register while it is free, and pops the next command only when back in idle.
// A 4-entry command queue lets the input side accept items while bytes are emitted.
// Reset (synchronous, rst_n low): no frame open, queue empty, output empty,
// header registers back to 0x12, 0x34, 0x56.
// ----------------------------------------------------------------------------
// crc16_arc_frame_builder_top: CRC-16/ARC command frame builder
// Front classifier, command queue, back-end byte emitter and header registers.
// ----------------------------------------------------------------------------
module crc16_arc_frame_builder_top #(
  parameter int BODY_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_command,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic [6:0] out_byte_index,
  output logic       out_last_byte,
  output logic       out_payload_dropped,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import cfb_pkg::*;

  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  logic       pop_valid, pop_ready;
  cmd_t       pop_cmd;
  logic [7:0] hdr_one_r, hdr_two_r, hdr_three_r;

  // Header registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_one_r   <= HDR_ONE_RST;
      hdr_two_r   <= HDR_TWO_RST;
      hdr_three_r <= HDR_THREE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HDR_ONE:   hdr_one_r   <= cfg_data;
        REG_HDR_TWO:   hdr_two_r   <= cfg_data;
        REG_HDR_THREE: hdr_three_r <= cfg_data;
        default: begin
          // unmapped index: write ignored
        end
      endcase
    end
  end

  // Classifier
  cfb_front #(.BODY_BYTES(BODY_BYTES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_command      (in_command),
    .in_payload_byte (in_payload_byte),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  // Command queue
  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Byte emitter
  cfb_back #(.BODY_BYTES(BODY_BYTES)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_cmd             (pop_cmd),
    .hdr_one             (hdr_one_r),
    .hdr_two             (hdr_two_r),
    .hdr_three           (hdr_three_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_byte_index      (out_byte_index),
    .out_last_byte       (out_last_byte),
    .out_payload_dropped (out_payload_dropped)
  );

endmodule

[src/cfb_front.sv]
// ----------------------------------------------------------------------------
// cfb_front: input classifier
// Accepts items, tracks frame state and body fill, drops overflowing payload
// and pushes start / payload / finish commands into the queue.
// ----------------------------------------------------------------------------
module cfb_front #(
  parameter int BODY_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_command,
  input  logic [7:0]    in_payload_byte,
  output logic          push_valid,
  input  logic          push_ready,
  output cfb_pkg::cmd_t push_cmd
);
  import cfb_pkg::*;

  localparam int CNT_W = $clog2(BODY_BYTES + 1);
  localparam logic [CNT_W-1:0] BODY_CNT = CNT_W'(BODY_BYTES);
  localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(HDR_BYTES);

  logic             open_r, open_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             want_push;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // Classify the item and update frame tracking
  always_comb begin
    open_nxt      = open_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    want_push     = 1'b0;
    push_cmd.kind = CMD_PAY;
    push_cmd.data = in_payload_byte;
    push_cmd.ovf  = ovf_r;
    unique case (in_op)
      OP_START: begin
        want_push     = 1'b1;
        push_cmd.kind = CMD_START;
        push_cmd.data = in_command;
        push_cmd.ovf  = 1'b0;
        open_nxt      = 1'b1;
        cnt_nxt       = HDR_CNT;
        ovf_nxt       = 1'b0;
      end
      OP_PAYLOAD: begin
        if (open_r) begin
          if (cnt_r < BODY_CNT) begin
            want_push = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      OP_FINISH: begin
        if (open_r) begin
          want_push     = 1'b1;
          push_cmd.kind = CMD_FIN;
          push_cmd.data = 8'h00;
          open_nxt      = 1'b0;
          cnt_nxt       = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
        // unused op: ignored
      end
    endcase
  end

  assign push_valid = accept && want_push;

  // Frame tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (accept) begin
      open_r <= open_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

[src/cfb_queue.sv]
// ----------------------------------------------------------------------------
// cfb_queue: command queue
// Small register FIFO that decouples the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module cfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  cfb_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cfb_pkg::cmd_t pop_cmd
);
  import cfb_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill_r != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

[src/cfb_back.sv]
// ----------------------------------------------------------------------------
// cfb_back: byte emitter
// Pops commands and emits frame bytes into the output register while it is free,
// running the CRC over body bytes and closing the frame with the CRC.
// ----------------------------------------------------------------------------
module cfb_back #(
  parameter int BODY_BYTES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  cfb_pkg::cmd_t pop_cmd,
  input  logic [7:0]    hdr_one,
  input  logic [7:0]    hdr_two,
  input  logic [7:0]    hdr_three,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_frame_byte,
  output logic [6:0]    out_byte_index,
  output logic          out_last_byte,
  output logic          out_payload_dropped
);
  import cfb_pkg::*;

  localparam int CNT_W = $clog2(BODY_BYTES + 1);
  localparam logic [CNT_W-1:0] BODY_CNT = CNT_W'(BODY_BYTES);
  localparam logic [6:0] IDX_CRC_LO = 7'(BODY_BYTES);
  localparam logic [6:0] IDX_CRC_HI = 7'(BODY_BYTES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_PAY,
    S_PAD,
    S_CRC_HI
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cur_r, cur_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [6:0]       out_idx_r, out_idx_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;
  logic             out_free;
  logic [15:0]      cnt_ext;
  logic [7:0]       hdr_sel;
  logic             body_emit;
  logic [7:0]       body_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = (state_r == S_IDLE);
  assign cnt_ext   = 16'(cnt_r);

  // Start bytes: command, then the three header registers
  always_comb begin
    case (sub_r)
      2'd0:    hdr_sel = cur_r.data;
      2'd1:    hdr_sel = hdr_one;
      2'd2:    hdr_sel = hdr_two;
      default: hdr_sel = hdr_three;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    sub_nxt       = sub_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    body_emit     = 1'b0;
    body_byte     = 8'h00;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          cur_nxt = pop_cmd;
          case (pop_cmd.kind)
            CMD_START: begin
              cnt_nxt   = '0;
              crc_nxt   = '0;
              sub_nxt   = '0;
              state_nxt = S_HDR;
            end
            CMD_PAY: state_nxt = S_PAY;
            CMD_FIN: state_nxt = S_PAD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HDR: begin
        if (out_free) begin
          body_emit = 1'b1;
          body_byte = hdr_sel;
          sub_nxt   = sub_r + 1'b1;
          if (sub_r == 2'd3) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PAY: begin
        if (out_free) begin
          body_emit = 1'b1;
          body_byte = cur_r.data;
          state_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        if (out_free) begin
          if (cnt_r == BODY_CNT) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = crc_r[7:0];
            out_idx_nxt   = IDX_CRC_LO;
            out_last_nxt  = 1'b0;
            out_ovf_nxt   = cur_r.ovf;
            state_nxt     = S_CRC_HI;
          end else begin
            body_emit = 1'b1;
            body_byte = 8'h00;
          end
        end
      end
      S_CRC_HI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_r[15:8];
          out_idx_nxt   = IDX_CRC_HI;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = cur_r.ovf;
          cnt_nxt       = '0;
          crc_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Body byte: load output, fold into CRC, advance position
    if (body_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = body_byte;
      out_idx_nxt   = cnt_ext[6:0];
      out_last_nxt  = 1'b0;
      out_ovf_nxt   = cur_r.ovf;
      crc_nxt       = crc16_arc_byte(crc_r, body_byte);
      cnt_nxt       = cnt_r + 1'b1;
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sub_r       <= '0;
      cnt_r       <= '0;
      crc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
    end
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_frame_byte      = out_byte_r;
  assign out_byte_index      = out_idx_r;
  assign out_last_byte       = out_last_r;
  assign out_payload_dropped = out_ovf_r;

endmodule

[src/cfb_checker.sv]
// ----------------------------------------------------------------------------
// cfb_checker: port-level checks of the frame builder
// Watches the result channel for frame-closing order and stall behavior.
// ----------------------------------------------------------------------------
module cfb_checker #(
  parameter int BODY_BYTES = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic [6:0] out_byte_index,
  input logic       out_last_byte,
  input logic       out_payload_dropped
);

  localparam logic [6:0] IDX_CRC_LO = 7'(BODY_BYTES);
  localparam logic [6:0] IDX_CRC_HI = 7'(BODY_BYTES + 1);

  // Last beat sits at the high CRC position
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte_index == IDX_CRC_HI)
    else $error("last beat at wrong index");

  // CRC low beat taken: high beat follows in the next cycle
  a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte && out_byte_index == IDX_CRC_LO
    |=> out_valid && out_last_byte)
    else $error("CRC high beat did not follow low beat");

  // The CRC high beat is never a payload-dropped flip from its low beat
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte && out_byte_index == IDX_CRC_LO
    |=> out_payload_dropped == $past(out_payload_dropped))
    else $error("drop flag changed within CRC");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_byte_index) && $stable(out_last_byte))
    else $error("stalled result beat changed");

endmodule

bind crc16_arc_frame_builder_top cfb_checker #(.BODY_BYTES(BODY_BYTES)) u_cfb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_frame_byte      (out_frame_byte),
  .out_byte_index      (out_byte_index),
  .out_last_byte       (out_last_byte),
  .out_payload_dropped (out_payload_dropped)
);

[tb/sv/tb_crc16_arc_frame_builder_top.sv]
// ----------------------------------------------------------------------------
// tb_crc16_arc_frame_builder_top: self-checking bench for the frame builder
// Drives start, payload and finish items under random input gaps and output
// stalls. A behavioral frame tracker predicts every frame beat: command,
// header and payload bytes, padding, dropped-payload flag and CRC-16/ARC
// trailer. Header registers are reprogrammed between traffic phases.
// ----------------------------------------------------------------------------
module tb_crc16_arc_frame_builder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfb_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 9;
  localparam int          FRAME_BODY   = 64;
  localparam int          QUIET_CYCLES = 24;
  localparam int          IDLE_LIMIT   = 3000;
  localparam int          PRINT_CAP    = 100;
  // op and register index values the block must ignore
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  // One frame beat as seen on the result channel
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [6:0] byte_index;
    logic       last_byte;
    logic       payload_dropped;
  } frame_beat_t;

  // Tracks the open frame and holds the beats the block still owes us
  class frame_tracker;
    int unsigned  body_len;
    logic [7:0]   hdr [3];
    bit           frame_open;
    int unsigned  fill;
    logic [15:0]  crc_acc;
    bit           dropped;
    frame_beat_t  owed_beats [$];
    int unsigned  errors;
    int unsigned  beat_no;

    function new(int unsigned body);
      body_len = body;
      hdr[0] = HDR_ONE_RST;
      hdr[1] = HDR_TWO_RST;
      hdr[2] = HDR_THREE_RST;
      frame_open = 0;
      fill = 0;
      crc_acc = '0;
      dropped = 0;
      errors = 0;
      beat_no = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_HDR_ONE:   hdr[0] = val;
        REG_HDR_TWO:   hdr[1] = val;
        REG_HDR_THREE: hdr[2] = val;
        default: ;
      endcase
    endfunction

    // LSB-first CRC-16/ARC, one bit per step
    function void crc_shift_in(logic [7:0] b);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = crc_acc[0] ^ b[i];
        crc_acc = crc_acc >> 1;
        if (fb) crc_acc = crc_acc ^ CRC_POLY;
      end
    endfunction

    function void owe(logic [7:0] b, int unsigned idx, bit last);
      frame_beat_t beat;
      beat.frame_byte      = b;
      beat.byte_index      = 7'(idx);
      beat.last_byte       = last;
      beat.payload_dropped = dropped;
      owed_beats.push_back(beat);
    endfunction

    function void owe_body(logic [7:0] b);
      owe(b, fill, 0);
      crc_shift_in(b);
      fill++;
    endfunction

    function void close_frame();
      frame_open = 0;
      fill = 0;
      crc_acc = '0;
      dropped = 0;
    endfunction

    // Returns 1 when the item does something, 0 when the block ignores it
    function bit note_item(logic [1:0] op, logic [7:0] cmd, logic [7:0] pay);
      case (op)
        OP_START: begin
          close_frame();
          frame_open = 1;
          owe_body(cmd);
          owe_body(hdr[0]);
          owe_body(hdr[1]);
          owe_body(hdr[2]);
          return 1;
        end
        OP_PAYLOAD: begin
          if (!frame_open) return 0;
          if (fill < body_len) owe_body(pay);
          else dropped = 1;
          return 1;
        end
        OP_FINISH: begin
          if (!frame_open) return 0;
          while (fill < body_len) owe_body(8'h00);
          owe(crc_acc[7:0], body_len, 0);
          owe(crc_acc[15:8], body_len + 1, 1);
          close_frame();
          return 1;
        end
        default: return 0;
      endcase
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("MISMATCH beat %0d %s: got %0h expected %0h", beat_no, what, got, want);
    endtask

    task check_beat(frame_beat_t got);
      frame_beat_t want;
      if (owed_beats.size() == 0) begin
        report("unexpected beat, byte", got.frame_byte, 8'h00);
      end else begin
        want = owed_beats.pop_front();
        if (got.frame_byte !== want.frame_byte)
          report("frame_byte", got.frame_byte, want.frame_byte);
        if (got.byte_index !== want.byte_index)
          report("byte_index", 8'(got.byte_index), 8'(want.byte_index));
        if (got.last_byte !== want.last_byte)
          report("last_byte", 8'(got.last_byte), 8'(want.last_byte));
        if (got.payload_dropped !== want.payload_dropped)
          report("payload_dropped", 8'(got.payload_dropped), 8'(want.payload_dropped));
      end
      beat_no++;
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_op;
  logic [7:0] in_command;
  logic [7:0] in_payload_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_frame_byte;
  logic [6:0] out_byte_index;
  logic       out_last_byte;
  logic       out_payload_dropped;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  frame_tracker book = new(FRAME_BODY);
  int unsigned  useful_items = 0;
  int unsigned  burst_left   = 0;
  int unsigned  idle_cycles  = 0;

  crc16_arc_frame_builder_top #(
    .BODY_BYTES(FRAME_BODY)
  ) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_command          (in_command),
    .in_payload_byte     (in_payload_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_byte      (out_frame_byte),
    .out_byte_index      (out_byte_index),
    .out_last_byte       (out_last_byte),
    .out_payload_dropped (out_payload_dropped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Input gap length: mostly short, a few long, occasional gap-free bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 5) begin
      burst_left = $urandom_range(30, 8);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // One input beat; valid stays high into the next call when the gap is zero
  task automatic send_item(logic [1:0] op, logic [7:0] cmd, logic [7:0] pay);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_command      <= cmd;
    in_payload_byte <= pay;
    do @(posedge clk); while (!in_ready);
    if (book.note_item(op, cmd, pay)) useful_items++;
  endtask

  task automatic write_header(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_headers(logic [7:0] one, logic [7:0] two, logic [7:0] three);
    write_header(REG_HDR_ONE, one);
    write_header(REG_HDR_TWO, two);
    write_header(REG_HDR_THREE, three);
    write_header(REG_UNUSED, 8'($urandom));
  endtask

  // Drop valid, wait for every owed beat, then let queued no-result items drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(int unsigned n_pay, bit finish);
    send_item(OP_START, 8'($urandom), 8'($urandom));
    repeat (n_pay) send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom));
    if (finish) send_item(OP_FINISH, 8'($urandom), 8'($urandom));
  endtask

  // Mostly complete frames with random content, plus abandoned frames and noise
  task automatic random_traffic(int unsigned quota, bit with_fill);
    int unsigned base;
    int unsigned r;
    int unsigned n_pay;
    base = useful_items;
    if (with_fill) begin
      // exactly full body, then a body that overflows
      send_frame(FRAME_BODY - HDR_BYTES, 1);
      send_frame(FRAME_BODY - HDR_BYTES + 3, 1);
    end
    while (useful_items - base < quota) begin
      r = $urandom_range(99);
      if (r < 65) n_pay = $urandom_range(6, 0);
      else if (r < 92) n_pay = $urandom_range(30, 7);
      else n_pay = $urandom_range(FRAME_BODY + 2, FRAME_BODY - 6);
      r = $urandom_range(99);
      if (r < 80) send_frame(n_pay, 1);
      else if (r < 88) send_frame(n_pay % 8, 0);
      else send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
    end
  endtask

  // Result-side back-pressure: short and long stalls, long stall-free runs
  always @(posedge clk) begin : ready_gen
    int unsigned r;
    int unsigned run_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      run_left = 0;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      r = $urandom_range(99);
      if (r < 30) begin
        out_ready <= 1'b1;
        run_left = $urandom_range(4, 1);
      end else if (r < 45) begin
        out_ready <= 1'b1;
        run_left = $urandom_range(80, 20);
      end else if (r < 85) begin
        out_ready <= 1'b0;
        run_left = $urandom_range(3, 1);
      end else if (r < 97) begin
        out_ready <= 1'b0;
        run_left = $urandom_range(10, 4);
      end else begin
        out_ready <= 1'b0;
        run_left = $urandom_range(40, 15);
      end
    end
  end

  // Result beat checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_beat({out_frame_byte, out_byte_index, out_last_byte, out_payload_dropped});
  end

  // Watchdog: cycles with no beat accepted on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op           <= OP_START;
    in_command      <= 8'h00;
    in_payload_byte <= 8'h00;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_HDR_ONE;
    cfg_data        <= 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: items outside a frame and the unused op are ignored
    send_item(OP_PAYLOAD, 8'h00, 8'hAA);
    send_item(OP_FINISH, 8'hFF, 8'h55);
    send_item(OP_UNUSED, 8'hFF, 8'hFF);
    // extreme command and payload values, reset headers
    send_item(OP_START, 8'h00, 8'hFF);
    send_item(OP_PAYLOAD, 8'hFF, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 8'hFF);
    send_item(OP_FINISH, 8'h00, 8'h00);
    // start while a frame is open abandons it; unused op inside a frame
    send_item(OP_START, 8'hFF, 8'h00);
    send_item(OP_PAYLOAD, 8'h00, 8'h5A);
    send_item(OP_START, 8'h81, 8'hFF);
    send_item(OP_PAYLOAD, 8'h00, 8'h7E);
    send_item(OP_UNUSED, 8'h00, 8'h00);
    send_item(OP_FINISH, 8'hFF, 8'hFF);
    // empty payload, then finish after close
    send_item(OP_START, 8'hC3, 8'h00);
    send_item(OP_FINISH, 8'h00, 8'h00);
    send_item(OP_FINISH, 8'h00, 8'h00);
    wait_idle();

    program_headers(8'h00, 8'hFF, 8'h00);
    random_traffic(128, 1);
    wait_idle();

    program_headers(8'hFF, 8'h00, 8'hFF);
    random_traffic(28, 0);
    wait_idle();

    program_headers(8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(28, 0);
    wait_idle();

    if (book.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
